### design/tcr_pkg.sv
`timescale 1ns / 1ps

package tcr_pkg;

    // Glyph memory geometry: 256 characters of 8 lines each.
    localparam int GLYPH_LINES = 8;
    localparam int GLYPH_DEPTH = 256 * GLYPH_LINES;

    // Cell signature: {0, char_code, attr}; all ones never matches a real one.
    localparam int SIG_W = 17;
    localparam logic [SIG_W-1:0] SIG_INVALID = 17'h1FFFF;

    // Job queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CURSOR_ENABLE = 2'd0,
        REG_CURSOR_COL    = 2'd1,
        REG_CURSOR_ROW    = 2'd2
    } cfg_reg_t;

    // Cursor settings as seen by the front.
    typedef struct packed {
        logic       enable;
        logic [6:0] col;
        logic [4:0] row;
    } cursor_t;

    // One queued job: either a font row load or a cell render.
    typedef struct packed {
        logic       is_load;
        logic [7:0] char_code;
        logic [2:0] load_line;
        logic [7:0] load_bits;
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] fg;
        logic [7:0] bg;
    } job_t;

    // Foreground level: 0 for index 0, otherwise 0x11*(i+1) capped at 0xFF.
    function automatic logic [7:0] fore_level(input logic [3:0] idx);
        logic [3:0] inc;
        inc = idx + 4'd1;
        if (idx == 4'd0) begin
            return 8'h00;
        end else if (idx == 4'hF) begin
            return 8'hFF;
        end else begin
            return {inc, inc};
        end
    endfunction

    // Background level: 0x11*i.
    function automatic logic [7:0] back_level(input logic [3:0] idx);
        return {idx, idx};
    endfunction

endpackage

### design/text_cell_renderer.sv
`timescale 1ns / 1ps

// 8x8 text-mode character generator. A font-load beat (kind 1) writes one glyph row.
// A render beat whose cell is redrawn, is the lit cursor, or has a changed character
// or attribute yields eight pixel-line beats, one per cycle while the output does not
// stall: the glyph memory read port serves one line per cycle. A render beat that is
// skipped or lies off the screen yields no beat. A four-entry job queue lets the input
// keep flowing while the output stalls. After reset the per-cell signature memory is
// cleared one cell per cycle, during which s_ready stays low; configuration writes are
// taken as ever. Every font row must be loaded before a cell using it is rendered.
module text_cell_renderer #(
    parameter int TEXT_COLS = 80,
    parameter int TEXT_ROWS = 25
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [6:0]                      s_col,
    input  logic [4:0]                      s_row,
    input  logic [7:0]                      s_char_code,
    input  logic [7:0]                      s_attr,
    input  logic [2:0]                      s_load_line,
    input  logic [7:0]                      s_load_bits,
    input  logic                            s_full_redraw,
    input  logic                            s_blink_on,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_pixel_row,
    output logic [9:0]                      m_pixel_col_start,
    output logic [7:0]                      m_green_0,
    output logic [7:0]                      m_green_1,
    output logic [7:0]                      m_green_2,
    output logic [7:0]                      m_green_3,
    output logic [7:0]                      m_green_4,
    output logic [7:0]                      m_green_5,
    output logic [7:0]                      m_green_6,
    output logic [7:0]                      m_green_7,
    output logic                            m_last_of_cell
);

    logic       cursor_enable_reg;
    logic [6:0] cursor_col_reg;
    logic [4:0] cursor_row_reg;

    tcr_pkg::cursor_t               cursor;
    logic                           push_valid;
    tcr_pkg::job_t                  push_job;
    logic                           pop;
    logic                           head_valid;
    tcr_pkg::job_t                  head_job;
    logic [tcr_pkg::QUEUE_AW:0]     q_level;

    // Cursor configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_enable_reg <= 1'b0;
            cursor_col_reg    <= '0;
            cursor_row_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tcr_pkg::REG_CURSOR_ENABLE: cursor_enable_reg <= cfg_wdata[0];
                tcr_pkg::REG_CURSOR_COL:    cursor_col_reg    <= cfg_wdata[6:0];
                tcr_pkg::REG_CURSOR_ROW:    cursor_row_reg    <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    assign cursor.enable = cursor_enable_reg;
    assign cursor.col    = cursor_col_reg;
    assign cursor.row    = cursor_row_reg;

    tcr_front #(
        .TEXT_COLS (TEXT_COLS),
        .TEXT_ROWS (TEXT_ROWS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_col         (s_col),
        .s_row         (s_row),
        .s_char_code   (s_char_code),
        .s_attr        (s_attr),
        .s_load_line   (s_load_line),
        .s_load_bits   (s_load_bits),
        .s_full_redraw (s_full_redraw),
        .s_blink_on    (s_blink_on),
        .cursor        (cursor),
        .q_level       (q_level),
        .push_valid    (push_valid),
        .push_job      (push_job)
    );

    tcr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .level      (q_level)
    );

    tcr_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_valid        (head_valid),
        .head_job          (head_job),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pixel_row       (m_pixel_row),
        .m_pixel_col_start (m_pixel_col_start),
        .m_green_0         (m_green_0),
        .m_green_1         (m_green_1),
        .m_green_2         (m_green_2),
        .m_green_3         (m_green_3),
        .m_green_4         (m_green_4),
        .m_green_5         (m_green_5),
        .m_green_6         (m_green_6),
        .m_green_7         (m_green_7),
        .m_last_of_cell    (m_last_of_cell)
    );

endmodule

### design/tcr_ram.sv
`timescale 1ns / 1ps

module tcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/tcr_front.sv
`timescale 1ns / 1ps

module tcr_front #(
    parameter int TEXT_COLS = 80,
    parameter int TEXT_ROWS = 25
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [6:0]                  s_col,
    input  logic [4:0]                  s_row,
    input  logic [7:0]                  s_char_code,
    input  logic [7:0]                  s_attr,
    input  logic [2:0]                  s_load_line,
    input  logic [7:0]                  s_load_bits,
    input  logic                        s_full_redraw,
    input  logic                        s_blink_on,
    input  tcr_pkg::cursor_t            cursor,
    input  logic [tcr_pkg::QUEUE_AW:0]  q_level,
    output logic                        push_valid,
    output tcr_pkg::job_t               push_job
);

    localparam int CELL_COUNT = TEXT_COLS * TEXT_ROWS;
    localparam int CELL_AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int LVL_W = tcr_pkg::QUEUE_AW + 2;

    // Clearing pass over the signature memory after reset.
    logic               clear_reg, clear_next;
    logic [CELL_AW-1:0] clear_addr_reg, clear_addr_next;

    // Classify stage: the item whose signature is being read.
    logic               st_valid_reg, st_valid_next;
    logic               st_load_reg;
    logic               st_in_bounds_reg;
    logic [CELL_AW-1:0] st_addr_reg;
    logic [6:0]         st_col_reg;
    logic [4:0]         st_row_reg;
    logic [7:0]         st_char_reg;
    logic [7:0]         st_attr_reg;
    logic [2:0]         st_load_line_reg;
    logic [7:0]         st_load_bits_reg;
    logic               st_redraw_reg;
    logic               st_blink_reg;

    // Last signature write, for an item whose read met that write.
    logic                        byp_valid_reg;
    logic [CELL_AW-1:0]          byp_addr_reg;
    logic [tcr_pkg::SIG_W-1:0]   byp_sig_reg;

    logic                        accept;
    logic [LVL_W-1:0]            level_sum;
    logic [15:0]                 cell_full;
    logic [CELL_AW-1:0]          cell_addr;
    logic                        in_bounds;
    logic                        sig_we;
    logic [CELL_AW-1:0]          sig_waddr;
    logic [tcr_pkg::SIG_W-1:0]   sig_wdata;
    logic [tcr_pkg::SIG_W-1:0]   sig_rdata;
    logic [tcr_pkg::SIG_W-1:0]   sig_old;
    logic [tcr_pkg::SIG_W-1:0]   sig_new;
    logic                        on_cursor;
    logic                        render;
    logic [7:0]                  fg_level;
    logic [7:0]                  bg_level;

    // Room is kept for the item in the classify stage and the one accepted now.
    assign level_sum = LVL_W'(q_level) + LVL_W'(st_valid_reg);
    assign s_ready   = !clear_reg && (level_sum < LVL_W'(tcr_pkg::QUEUE_DEPTH));
    assign accept    = s_valid && s_ready;

    // Cell index and screen bounds of the incoming beat.
    assign cell_full = 16'(s_row) * 16'(TEXT_COLS) + 16'(s_col);
    assign cell_addr = cell_full[CELL_AW-1:0];
    assign in_bounds = (9'(s_col) < 9'(TEXT_COLS)) && (7'(s_row) < 7'(TEXT_ROWS));

    // Render decision in the classify stage.
    assign sig_new   = {1'b0, st_char_reg, st_attr_reg};
    assign sig_old   = (byp_valid_reg && (byp_addr_reg == st_addr_reg)) ? byp_sig_reg
                                                                        : sig_rdata;
    assign on_cursor = cursor.enable && st_blink_reg &&
                       (st_col_reg == cursor.col) && (st_row_reg == cursor.row);
    assign render    = st_valid_reg && !st_load_reg && st_in_bounds_reg &&
                       (st_redraw_reg || on_cursor || (sig_old != sig_new));

    // Signature memory write: the clearing pass or a rendered cell.
    assign sig_we    = clear_reg || render;
    assign sig_waddr = clear_reg ? clear_addr_reg : st_addr_reg;
    assign sig_wdata = clear_reg ? tcr_pkg::SIG_INVALID : sig_new;

    tcr_ram #(
        .WIDTH (tcr_pkg::SIG_W),
        .DEPTH (CELL_COUNT)
    ) u_sig_ram (
        .aclk  (aclk),
        .we    (sig_we),
        .waddr (sig_waddr),
        .wdata (sig_wdata),
        .re    (accept),
        .raddr (cell_addr),
        .rdata (sig_rdata)
    );

    // Colors, swapped on the cursor cell.
    assign fg_level = tcr_pkg::fore_level(st_attr_reg[3:0]);
    assign bg_level = tcr_pkg::back_level(st_attr_reg[7:4]);

    always_comb begin
        push_valid         = st_valid_reg && (st_load_reg || render);
        push_job.is_load   = st_load_reg;
        push_job.char_code = st_char_reg;
        push_job.load_line = st_load_line_reg;
        push_job.load_bits = st_load_bits_reg;
        push_job.row       = st_row_reg;
        push_job.col       = st_col_reg;
        push_job.fg        = on_cursor ? bg_level : fg_level;
        push_job.bg        = on_cursor ? fg_level : bg_level;
    end

    // Next state of the clearing pass and the classify stage.
    always_comb begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg) begin
            clear_addr_next = clear_addr_reg + CELL_AW'(1);
            if (clear_addr_reg == CELL_AW'(CELL_COUNT - 1)) begin
                clear_next = 1'b0;
            end
        end
        st_valid_next = accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
            st_valid_reg   <= 1'b0;
            byp_valid_reg  <= 1'b0;
        end else begin
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
            st_valid_reg   <= st_valid_next;
            byp_valid_reg  <= sig_we;
        end
        byp_addr_reg <= sig_waddr;
        byp_sig_reg  <= sig_wdata;
        if (accept) begin
            st_load_reg      <= s_kind;
            st_in_bounds_reg <= in_bounds;
            st_addr_reg      <= cell_addr;
            st_col_reg       <= s_col;
            st_row_reg       <= s_row;
            st_char_reg      <= s_char_code;
            st_attr_reg      <= s_attr;
            st_load_line_reg <= s_load_line;
            st_load_bits_reg <= s_load_bits;
            st_redraw_reg    <= s_full_redraw;
            st_blink_reg     <= s_blink_on;
        end
    end

    // No beat is taken while the signature memory is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_reg |-> !s_ready)
        else $error("input accepted during signature clearing pass");

    // A render item off the screen never reaches the queue.
    a_off_screen_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && !st_load_reg && !st_in_bounds_reg) |-> !push_valid)
        else $error("off-screen cell was queued");

endmodule

### design/tcr_queue.sv
`timescale 1ns / 1ps

module tcr_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push_valid,
    input  tcr_pkg::job_t               push_job,
    input  logic                        pop,
    output logic                        head_valid,
    output tcr_pkg::job_t               head_job,
    output logic [tcr_pkg::QUEUE_AW:0]  level
);

    tcr_pkg::job_t                   entry_reg [tcr_pkg::QUEUE_DEPTH];
    logic [tcr_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tcr_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tcr_pkg::QUEUE_AW:0]      level_reg, level_next;
    logic                            do_pop;

    assign head_valid = (level_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign do_pop     = pop && head_valid;

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push_valid && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (!push_valid && do_pop) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (level_reg < (tcr_pkg::QUEUE_AW + 1)'(tcr_pkg::QUEUE_DEPTH)))
        else $error("job queue overflow");

endmodule

### design/tcr_back.sv
`timescale 1ns / 1ps

module tcr_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  tcr_pkg::job_t    head_job,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_pixel_row,
    output logic [9:0]       m_pixel_col_start,
    output logic [7:0]       m_green_0,
    output logic [7:0]       m_green_1,
    output logic [7:0]       m_green_2,
    output logic [7:0]       m_green_3,
    output logic [7:0]       m_green_4,
    output logic [7:0]       m_green_5,
    output logic [7:0]       m_green_6,
    output logic [7:0]       m_green_7,
    output logic             m_last_of_cell
);

    localparam int GLYPH_AW = $clog2(tcr_pkg::GLYPH_DEPTH);

    // Line counter of the render job at the queue head.
    logic [2:0] line_cnt_reg, line_cnt_next;

    // Glyph read stage: metadata of the line whose glyph row is in flight.
    logic       p1_valid_reg, p1_valid_next;
    logic [4:0] p1_row_reg;
    logic [6:0] p1_col_reg;
    logic [2:0] p1_line_reg;
    logic [7:0] p1_fg_reg;
    logic [7:0] p1_bg_reg;

    // Output register.
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_pixel_row_reg;
    logic [9:0] m_pixel_col_start_reg;
    logic [7:0] green_reg [8];
    logic       m_last_reg;

    logic                head_load;
    logic                head_render;
    logic                out_free;
    logic                p1_adv;
    logic                can_issue;
    logic                issue;
    logic [GLYPH_AW-1:0] glyph_waddr;
    logic [GLYPH_AW-1:0] glyph_raddr;
    logic [7:0]          glyph_bits;

    assign head_load   = head_valid && head_job.is_load;
    assign head_render = head_valid && !head_job.is_load;

    // A glyph read is issued only when the glyph read stage is empty or moving on to the output register.
    assign out_free  = !m_valid_reg || m_ready;
    assign p1_adv    = p1_valid_reg && out_free;
    assign can_issue = !p1_valid_reg || p1_adv;
    assign issue     = head_render && can_issue;

    // Loads write in queue order; a render leaves after its eighth line.
    assign pop = head_load || (issue && (line_cnt_reg == 3'd7));

    assign glyph_waddr = {head_job.char_code, head_job.load_line};
    assign glyph_raddr = {head_job.char_code, line_cnt_reg};

    tcr_ram #(
        .WIDTH (8),
        .DEPTH (tcr_pkg::GLYPH_DEPTH)
    ) u_glyph_ram (
        .aclk  (aclk),
        .we    (head_load),
        .waddr (glyph_waddr),
        .wdata (head_job.load_bits),
        .re    (issue),
        .raddr (glyph_raddr),
        .rdata (glyph_bits)
    );

    // Control next state.
    always_comb begin
        line_cnt_next = issue ? line_cnt_reg + 3'd1 : line_cnt_reg;
        p1_valid_next = p1_valid_reg;
        if (issue) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_cnt_reg <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            line_cnt_reg <= line_cnt_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        if (issue) begin
            p1_row_reg  <= head_job.row;
            p1_col_reg  <= head_job.col;
            p1_line_reg <= line_cnt_reg;
            p1_fg_reg   <= head_job.fg;
            p1_bg_reg   <= head_job.bg;
        end
        // The glyph MSB is the leftmost pixel.
        if (p1_adv) begin
            m_pixel_row_reg       <= {p1_row_reg, p1_line_reg};
            m_pixel_col_start_reg <= {p1_col_reg, 3'b000};
            m_last_reg            <= (p1_line_reg == 3'd7);
            for (int i = 0; i < 8; i++) begin
                green_reg[i] <= glyph_bits[7 - i] ? p1_fg_reg : p1_bg_reg;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_pixel_row       = m_pixel_row_reg;
    assign m_pixel_col_start = m_pixel_col_start_reg;
    assign m_green_0         = green_reg[0];
    assign m_green_1         = green_reg[1];
    assign m_green_2         = green_reg[2];
    assign m_green_3         = green_reg[3];
    assign m_green_4         = green_reg[4];
    assign m_green_5         = green_reg[5];
    assign m_green_6         = green_reg[6];
    assign m_green_7         = green_reg[7];
    assign m_last_of_cell    = m_last_reg;

    // The last-of-cell flag marks exactly the eighth line of a cell.
    a_last_on_line7: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_last_reg == (m_pixel_row_reg[2:0] == 3'd7)))
        else $error("last_of_cell does not match the pixel line");

    // A render in progress keeps its job at the queue head.
    a_render_holds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_cnt_reg != 3'd0) |-> (head_valid && !head_job.is_load))
        else $error("render job left the queue head mid-cell");

endmodule
